### hdl/assert_macros.svh
// Assertion macros for the translator RTL; the table walker includes them.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds at the same edge
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence holds at the following edge
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/dpat_pkg.sv
// Package for the demand paged address translator.
// Holds address layout constants, default table sizes, walker states and the result type.
package dpat_pkg;

  localparam int ADDR_W      = 32;
  localparam int HOST_W      = 64;
  localparam int BASE_W      = 52;
  localparam int FRAME_OUT_W = 12;
  localparam int PAGE_SHIFT  = 12;
  localparam int IDX_W       = 9;
  localparam int ROOT_W      = 2;
  localparam int ROOT_N      = 1 << ROOT_W;
  localparam int TABLE_N     = 1 << IDX_W;

  localparam int LEVEL1_TABLES_DEF = 4;
  localparam int LEVEL2_TABLES_DEF = 64;
  localparam int FRAMES_DEF        = 4096;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_L1,
    ST_L2,
    ST_FIN
  } walk_state_t;

  typedef struct packed {
    logic [HOST_W-1:0]      host_address;
    logic [FRAME_OUT_W-1:0] frame_number;
    logic [1:0]             tables_created;
    logic                   page_created;
    logic                   fault;
  } result_t;

endpackage

### hdl/dpat_if.sv
// Request and response channel interfaces of the translator.
// Depends on dpat_pkg for field widths.
interface dpat_req_if import dpat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] guest_address;

  modport source (output valid, output guest_address, input ready);
  modport sink (input valid, input guest_address, output ready);
endinterface

interface dpat_rsp_if import dpat_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [HOST_W-1:0]      host_address;
  logic [FRAME_OUT_W-1:0] frame_number;
  logic [1:0]             tables_created;
  logic                   page_created;
  logic                   fault;

  modport source (output valid, output host_address, output frame_number,
                  output tables_created, output page_created, output fault, input ready);
  modport sink (input valid, input host_address, input frame_number,
                input tables_created, input page_created, input fault, output ready);
endinterface

### hdl/dpat_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module dpat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/dpat_walk.sv
// Table walker: root table registers, level-1 and level-2 table RAMs, bump allocators.
// Depends on dpat_pkg, dpat_if, dpat_ram and assert_macros.svh.
`include "assert_macros.svh"

module dpat_walk import dpat_pkg::*; #(
  parameter int LEVEL1_TABLES = LEVEL1_TABLES_DEF,
  parameter int LEVEL2_TABLES = LEVEL2_TABLES_DEF,
  parameter int FRAMES        = FRAMES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  dpat_req_if.sink          req,
  input  logic [BASE_W-1:0] pool_page_base,
  output result_t           res,
  output logic              res_valid,
  input  logic              res_ready
);

  localparam int T1_W      = (LEVEL1_TABLES > 1) ? $clog2(LEVEL1_TABLES) : 1;
  localparam int T2_W      = (LEVEL2_TABLES > 1) ? $clog2(LEVEL2_TABLES) : 1;
  localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int L1CNT_W   = $clog2(LEVEL1_TABLES + 1);
  localparam int L2CNT_W   = $clog2(LEVEL2_TABLES + 1);
  localparam int FCNT_W    = $clog2(FRAMES + 1);
  localparam int L1_AW     = T1_W + IDX_W;
  localparam int L2_AW     = T2_W + IDX_W;
  localparam int L1_DEPTH  = LEVEL1_TABLES * TABLE_N;
  localparam int L2_DEPTH  = LEVEL2_TABLES * TABLE_N;
  localparam int L1_DW     = T2_W + 1;
  localparam int L2_DW     = FRAME_W + 1;
  localparam int CLR_AW    = (L1_AW > L2_AW) ? L1_AW : L2_AW;
  localparam int CLR_DEPTH = (L1_DEPTH > L2_DEPTH) ? L1_DEPTH : L2_DEPTH;

  walk_state_t state, state_next;

  logic [ADDR_W-1:0]  addr;
  logic [CLR_AW-1:0]  clr_cnt;
  logic               root_vld [ROOT_N];
  logic [T1_W-1:0]    root_idx [ROOT_N];
  logic [L1CNT_W-1:0] l1_used;
  logic [L2CNT_W-1:0] l2_used;
  logic [FCNT_W-1:0]  frames_used;
  logic               need1_q;
  logic [T1_W-1:0]    t1_q;
  logic               need2_q;
  logic [T2_W-1:0]    t2_q;

  logic [ROOT_W-1:0]     i0;
  logic [IDX_W-1:0]      i1;
  logic [IDX_W-1:0]      i2;
  logic [PAGE_SHIFT-1:0] offset;

  logic             l1_we, l1_re, l2_we, l2_re;
  logic [L1_AW-1:0] l1_waddr, l1_raddr;
  logic [L2_AW-1:0] l2_waddr, l2_raddr;
  logic [L1_DW-1:0] l1_wdata, l1_rdata;
  logic [L2_DW-1:0] l2_wdata, l2_rdata;

  logic              clearing, clr_last, clr_l1, clr_l2;
  logic [T1_W-1:0]   root_t1;
  logic              need2, need3, fault, commit;
  logic [T2_W-1:0]   t2_rd;
  logic [T1_W-1:0]   new_t1;
  logic [T2_W-1:0]   new_t2;
  logic [FRAME_W-1:0] frame;
  logic [HOST_W-1:0]  frame_wide;
  logic [HOST_W-1:0]  host;

  assign i0     = addr[PAGE_SHIFT + 2*IDX_W +: ROOT_W];
  assign i1     = addr[PAGE_SHIFT + IDX_W +: IDX_W];
  assign i2     = addr[PAGE_SHIFT +: IDX_W];
  assign offset = addr[PAGE_SHIFT-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (req.valid) state_next = ST_L1;
      ST_L1:    state_next = ST_L2;
      ST_L2:    state_next = ST_FIN;
      ST_FIN:   if (res_ready) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    req.ready = 1'b0;
    clearing  = 1'b0;
    l1_re     = 1'b0;
    l2_re     = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      ST_CLEAR: clearing  = 1'b1;
      ST_IDLE:  req.ready = 1'b1;
      ST_L1:    l1_re     = 1'b1;
      ST_L2:    l2_re     = 1'b1;
      ST_FIN:   res_valid = 1'b1;
      default:  clearing  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // walk datapath
  always_comb begin
    clr_last = (clr_cnt == CLR_AW'(CLR_DEPTH - 1));
    clr_l1   = clearing && ({1'b0, clr_cnt} < (CLR_AW + 1)'(L1_DEPTH));
    clr_l2   = clearing && ({1'b0, clr_cnt} < (CLR_AW + 1)'(L2_DEPTH));

    root_t1  = root_vld[i0] ? root_idx[i0] : '0;
    l1_raddr = {root_t1, i1};

    need2    = need1_q || !l1_rdata[T2_W];
    t2_rd    = need2 ? '0 : l1_rdata[T2_W-1:0];
    l2_raddr = {t2_rd, i2};

    need3 = need2_q || !l2_rdata[FRAME_W];
    frame = need3 ? frames_used[FRAME_W-1:0] : l2_rdata[FRAME_W-1:0];
    fault = (need1_q && (l1_used >= L1CNT_W'(LEVEL1_TABLES))) ||
            (need2_q && (l2_used >= L2CNT_W'(LEVEL2_TABLES))) ||
            (need3 && (frames_used >= FCNT_W'(FRAMES)));
    commit = res_valid && res_ready && !fault;

    new_t1 = need1_q ? l1_used[T1_W-1:0] : t1_q;
    new_t2 = need2_q ? l2_used[T2_W-1:0] : t2_q;

    frame_wide = HOST_W'(frame);
    host = ((HOST_W'(pool_page_base) + frame_wide) << PAGE_SHIFT) | HOST_W'(offset);

    if (fault) begin
      res = '0;
      res.fault = 1'b1;
    end else begin
      res.host_address   = host;
      res.frame_number   = frame_wide[FRAME_OUT_W-1:0];
      res.tables_created = 2'(need1_q) + 2'(need2_q);
      res.page_created   = need3;
      res.fault          = 1'b0;
    end

    if (clearing) begin
      l1_we    = clr_l1;
      l1_waddr = clr_cnt[L1_AW-1:0];
      l1_wdata = '0;
      l2_we    = clr_l2;
      l2_waddr = clr_cnt[L2_AW-1:0];
      l2_wdata = '0;
    end else begin
      l1_we    = commit && need2_q;
      l1_waddr = {new_t1, i1};
      l1_wdata = {1'b1, new_t2};
      l2_we    = commit && need3;
      l2_waddr = {new_t2, i2};
      l2_wdata = {1'b1, frame};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt     <= '0;
      l1_used     <= '0;
      l2_used     <= '0;
      frames_used <= '0;
      for (int k = 0; k < ROOT_N; k++) begin
        root_vld[k] <= 1'b0;
      end
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + CLR_AW'(1);
      end
      if (commit) begin
        if (need1_q) begin
          l1_used      <= l1_used + L1CNT_W'(1);
          root_vld[i0] <= 1'b1;
        end
        if (need2_q) begin
          l2_used <= l2_used + L2CNT_W'(1);
        end
        if (need3) begin
          frames_used <= frames_used + FCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      addr <= req.guest_address;
    end
    if (commit && need1_q) begin
      root_idx[i0] <= new_t1;
    end
    if (l1_re) begin
      need1_q <= !root_vld[i0];
      t1_q    <= root_t1;
    end
    if (l2_re) begin
      need2_q <= need2;
      t2_q    <= t2_rd;
    end
  end

  dpat_ram #(.WIDTH(L1_DW), .DEPTH(L1_DEPTH), .AW(L1_AW)) u_l1_ram (
    .clk   (clk),
    .we    (l1_we),
    .waddr (l1_waddr),
    .wdata (l1_wdata),
    .re    (l1_re),
    .raddr (l1_raddr),
    .rdata (l1_rdata)
  );

  dpat_ram #(.WIDTH(L2_DW), .DEPTH(L2_DEPTH), .AW(L2_AW)) u_l2_ram (
    .clk   (clk),
    .we    (l2_we),
    .waddr (l2_waddr),
    .wdata (l2_wdata),
    .re    (l2_re),
    .raddr (l2_raddr),
    .rdata (l2_rdata)
  );

  `ASSERT_HOLDS(a_counts_bounded, (l1_used <= L1CNT_W'(LEVEL1_TABLES)) && (l2_used <= L2CNT_W'(LEVEL2_TABLES)) && (frames_used <= FCNT_W'(FRAMES)), "allocator count beyond its pool")
  `ASSERT_NEXT(a_fault_keeps_counts, res_valid && res_ready && res.fault, $stable(l1_used) && $stable(l2_used) && $stable(frames_used), "faulting request changed an allocator")
  `ASSERT_IMPLIES(a_table_implies_page, res_valid && !res.fault && (res.tables_created != 2'd0), res.page_created, "new table without new page")
  `ASSERT_NEXT(a_page_advances_frames, res_valid && res_ready && res.page_created, frames_used == $past(frames_used) + FCNT_W'(1), "new page did not advance frame allocator")

endmodule

### hdl/demand_paged_address_translator_core.sv
// Top level of the demand paged address translator: pool base register and result register.
// Depends on dpat_pkg, dpat_if and dpat_walk.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+------------------------------------------------
//   req      | in  | valid / ready     | guest_address
//   rsp      | out | valid / ready     | host_address, frame_number, tables_created,
//            |     |                   | page_created, fault
//   cfg      | in  | cfg_we            | cfg_data (pool_page_base)
//
// A request passes through accept, level-1 table read, level-2 table read, resolve and
// write-back in turn; the two dependent reads of the table RAMs set this order.
// After reset a clearing pass writes every table RAM entry invalid, one entry a cycle, over
// max(LEVEL1_TABLES, LEVEL2_TABLES) * 512 rows (32768 by default); no request is taken then.
// A result waits in the output register; the next request is accepted meanwhile and its walk
// holds in the resolve step until the output register frees.
module demand_paged_address_translator_core import dpat_pkg::*; #(
  parameter int LEVEL1_TABLES = LEVEL1_TABLES_DEF,
  parameter int LEVEL2_TABLES = LEVEL2_TABLES_DEF,
  parameter int FRAMES        = FRAMES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [BASE_W-1:0] cfg_data,
  dpat_req_if.sink          req,
  dpat_rsp_if.source        rsp
);

  logic [BASE_W-1:0] pool_page_base;
  result_t           res;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid;
  result_t           out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_page_base <= '0;
    end else if (cfg_we) begin
      pool_page_base <= cfg_data;
    end
  end

  dpat_walk #(
    .LEVEL1_TABLES (LEVEL1_TABLES),
    .LEVEL2_TABLES (LEVEL2_TABLES),
    .FRAMES        (FRAMES)
  ) u_walk (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .pool_page_base (pool_page_base),
    .res            (res),
    .res_valid      (res_valid),
    .res_ready      (res_ready)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.host_address   = out_data.host_address;
  assign rsp.frame_number   = out_data.frame_number;
  assign rsp.tables_created = out_data.tables_created;
  assign rsp.page_created   = out_data.page_created;
  assign rsp.fault          = out_data.fault;

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Testbench for demand_paged_address_translator_core: drives guest addresses, predicts every
// translation with its own page-table walker and checks each response field by field.
// Depends on dpat_pkg, dpat_if and the core RTL.
module tb;
  import dpat_pkg::*;

  localparam int L1_N = LEVEL1_TABLES_DEF;
  localparam int L2_N = LEVEL2_TABLES_DEF;
  localparam int FRAME_N = FRAMES_DEF;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MIX_COUNT = 1300;
  localparam int QUIET_TAIL = 150;
  localparam logic [ROOT_W-1:0] ROOT_SPARE = 2'd2;
  localparam logic [ROOT_W-1:0] ROOT_LAST = 2'd3;
  localparam logic [BASE_W-1:0] BASE_TOP = 52'hF_FFFF_FFFF_F000;
  localparam logic [BASE_W-1:0] BASE_ONES = '1;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [BASE_W-1:0] cfg_data;

  dpat_req_if req ();
  dpat_rsp_if rsp ();

  demand_paged_address_translator_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req.sink),
    .rsp      (rsp.source)
  );

  always #5 clk = ~clk;

  // shadow page tables and allocators
  logic [BASE_W-1:0] pool_base = '0;
  bit          root_ok [ROOT_N];
  int unsigned root_l1 [ROOT_N];
  bit          l1_ok [L1_N*TABLE_N];
  int unsigned l1_l2 [L1_N*TABLE_N];
  bit          l2_ok [L2_N*TABLE_N];
  int unsigned l2_frame [L2_N*TABLE_N];
  int unsigned level1_used = 0;
  int unsigned level2_used = 0;
  int unsigned frames_used = 0;
  logic [ROOT_W+IDX_W-1:0]   mapped_regions[$];
  logic [ROOT_W+2*IDX_W-1:0] touched_pages[$];

  result_t expected_results[$];
  int unsigned errors = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned faults_seen = 0;
  int unsigned base_writes = 0;
  int unsigned cycle_count = 0;

  bit req_idling = 1'b1;
  bit rsp_idling = 1'b1;
  int unsigned rsp_stall_left = 0;
  int unsigned rsp_hold_left = 0;

  function automatic bit region_mapped(input logic [ROOT_W+IDX_W-1:0] region);
    logic [ROOT_W-1:0] ri;
    logic [IDX_W-1:0] i1;
    {ri, i1} = region;
    return root_ok[ri] && l1_ok[root_l1[ri]*TABLE_N + i1];
  endfunction

  function automatic result_t translate(input logic [ADDR_W-1:0] ga);
    logic [ROOT_W-1:0] ri;
    logic [IDX_W-1:0] i1, i2;
    logic [PAGE_SHIFT-1:0] off;
    logic [HOST_W-1:0] host;
    bit need1, need2, need3;
    int unsigned t1, t2, fr;
    result_t r;
    {ri, i1, i2, off} = ga;
    t1 = 0;
    t2 = 0;
    fr = 0;
    r = '0;
    need1 = !root_ok[ri];
    if (!need1) t1 = root_l1[ri];
    need2 = need1 || !l1_ok[t1*TABLE_N + i1];
    if (!need2) t2 = l1_l2[t1*TABLE_N + i1];
    need3 = need2 || !l2_ok[t2*TABLE_N + i2];
    if (!need3) fr = l2_frame[t2*TABLE_N + i2];
    if ((need1 && level1_used >= L1_N) || (need2 && level2_used >= L2_N) ||
        (need3 && frames_used >= FRAME_N)) begin
      r.fault = 1'b1;
      return r;
    end
    if (need1) begin
      t1 = level1_used++;
      root_ok[ri] = 1'b1;
      root_l1[ri] = t1;
    end
    if (need2) begin
      t2 = level2_used++;
      l1_ok[t1*TABLE_N + i1] = 1'b1;
      l1_l2[t1*TABLE_N + i1] = t2;
      mapped_regions.push_back({ri, i1});
    end
    if (need3) begin
      fr = frames_used++;
      l2_ok[t2*TABLE_N + i2] = 1'b1;
      l2_frame[t2*TABLE_N + i2] = fr;
      touched_pages.push_back({ri, i1, i2});
    end
    host = {{(HOST_W-BASE_W){1'b0}}, pool_base} + HOST_W'(fr);
    r.host_address = (host << PAGE_SHIFT) + HOST_W'(off);
    r.frame_number = fr[FRAME_OUT_W-1:0];
    r.tables_created = 2'(need1) + 2'(need2);
    r.page_created = need3;
    return r;
  endfunction

  task automatic send_request(input logic [ADDR_W-1:0] ga);
    int unsigned gap;
    gap = (req_idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    repeat (gap) begin
      @(negedge clk);
      req.valid = 1'b0;
      req.guest_address = $urandom;
    end
    @(negedge clk);
    req.valid = 1'b1;
    req.guest_address = ga;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_results.push_back(translate(ga));
    requests_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_pool_base(input logic [BASE_W-1:0] b);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = b;
    @(negedge clk);
    cfg_we = 1'b0;
    pool_base = b;
    base_writes++;
  endtask

  function automatic logic [ADDR_W-1:0] revisit_address();
    return {touched_pages[$urandom_range(0, touched_pages.size()-1)], 12'($urandom)};
  endfunction

  task automatic test_directed();
    write_pool_base('0);
    send_request(32'h0000_0000);
    send_request(32'h0000_0FFF);
    send_request(32'h0000_1ABC);
    send_request(32'h001F_F000);
    send_request(32'h0020_0123);
    send_request(32'h3FE0_0000);
    send_request(32'h4000_0000);
    send_request(32'hFFFF_FFFF);
    send_request(32'hFFFF_F000);
    send_request(32'hC000_0000);
    send_request(32'h0000_0000);
    send_request(32'h4000_0FFF);
  endtask

  task automatic test_pool_base();
    logic [BASE_W-1:0] bases [4];
    bases = '{BASE_TOP, BASE_ONES, BASE_W'({$urandom, $urandom}), '0};
    foreach (bases[k]) begin
      wait_drained();
      write_pool_base(bases[k]);
      send_request(32'h0000_0777);
      send_request(32'hFFFF_FABC);
      send_request(32'h0000_2000 + (k << PAGE_SHIFT) + 12'hFFF);
    end
  endtask

  task automatic test_level2_exhaustion();
    logic [ROOT_W-1:0] ri;
    logic [IDX_W-1:0] i1;
    while (level2_used < L2_N) begin
      ri = ROOT_W'($urandom_range(0, 2));
      if (ri == ROOT_SPARE) ri = ROOT_LAST;
      i1 = IDX_W'($urandom);
      if (!region_mapped({ri, i1})) send_request({ri, i1, 9'($urandom), 12'($urandom)});
    end
    // spare root would still get a level-1 table, but the level-2 pool is empty
    repeat (3) send_request({ROOT_SPARE, 30'($urandom)});
    repeat (3) begin
      i1 = IDX_W'($urandom);
      while (region_mapped({2'd0, i1})) i1 = IDX_W'($urandom);
      send_request({2'd0, i1, 9'($urandom), 12'($urandom)});
    end
    repeat (4) send_request(revisit_address());
  endtask

  task automatic test_output_hold();
    wait_drained();
    rsp_hold_left = LONG_HOLD_CYCLES;
    repeat (30) send_request({mapped_regions[$urandom_range(0, mapped_regions.size()-1)],
                              9'($urandom), 12'($urandom)});
  endtask

  task automatic test_random_mix(input int unsigned count);
    int unsigned pick;
    logic [ADDR_W-1:0] ga;
    for (int n = 0; n < count; n++) begin
      if (n % 200 == 100 && n < count - QUIET_TAIL) begin
        req_idling = $urandom_range(0, 2) != 0;
        rsp_idling = $urandom_range(0, 2) != 0;
      end
      if (n == count - QUIET_TAIL) begin
        req_idling = 1'b0;
        rsp_idling = 1'b0;
      end
      if (n == count / 2) begin
        wait_drained();
        write_pool_base(BASE_W'({$urandom, $urandom}) % BASE_TOP);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60)
        ga = {mapped_regions[$urandom_range(0, mapped_regions.size()-1)],
              9'($urandom), 12'($urandom)};
      else if (pick < 85)
        ga = revisit_address();
      else
        ga = $urandom;
      send_request(ga);
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      results_seen++;
      if (rsp.fault === 1'b1) faults_seen++;
      if (expected_results.size() == 0) begin
        $error("response with no request outstanding: host_address 0x%0h", rsp.host_address);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("host_address", want.host_address, rsp.host_address);
        check_field("frame_number", 64'(want.frame_number), 64'(rsp.frame_number));
        check_field("tables_created", 64'(want.tables_created), 64'(rsp.tables_created));
        check_field("page_created", 64'(want.page_created), 64'(rsp.page_created));
        check_field("fault", 64'(want.fault), 64'(rsp.fault));
      end
    end
  end

  always @(negedge clk) begin
    if (rsp_hold_left > 0) begin
      rsp.ready = 1'b0;
      rsp_hold_left--;
    end else if (rsp_stall_left > 0) begin
      rsp.ready = 1'b0;
      rsp_stall_left--;
    end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
      rsp.ready = 1'b0;
      rsp_stall_left = $urandom_range(1, 10) - 1;
    end else begin
      rsp.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               expected_results.size());
      $display("** demand_paged_address_translator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.guest_address = '0;
    rsp.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_pool_base();
    test_level2_exhaustion();
    test_output_hold();
    test_random_mix(MIX_COUNT);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d translations checked, %0d of them faults; %0d frames and %0d level-2 tables",
             results_seen, faults_seen, frames_used, level2_used);
    $display("allocated, pool base written %0d times including both range ends and all ones",
             base_writes);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** demand_paged_address_translator_core: PASSED **");
    end else begin
      $display("** demand_paged_address_translator_core: FAILED **");
    end
    $finish;
  end

endmodule
